// ----- hdl/remote_parameter_access_client_core_assert.svh -----
// ---------------------------------------------------------------------------
// remote parameter access client assertion macros
// concurrent check helpers shared by the client rtl
// ---------------------------------------------------------------------------
`ifndef REMOTE_PARAMETER_ACCESS_CLIENT_CORE_ASSERT_SVH
`define REMOTE_PARAMETER_ACCESS_CLIENT_CORE_ASSERT_SVH

// same-cycle implication, checked on every aclk edge outside reset
`define RPAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every aclk edge outside reset
`define RPAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rpac_pkg.sv -----
// ---------------------------------------------------------------------------
// rpac_pkg
// types, codes and constants of the remote parameter access client
// ---------------------------------------------------------------------------
package rpac_pkg;

    // frame descriptors and field masks
    localparam logic [15:0] DESC_REPLY = 16'h6265;
    localparam logic [15:0] DESC_WRITE = 16'h6205;
    localparam logic [15:0] DESC_QUERY = 16'h0E01;
    localparam logic [6:0]  ID_MASK    = 7'h7F;
    localparam logic [2:0]  LEN_QUERY  = 3'd1;
    localparam logic [2:0]  LEN_WRITE  = 3'd5;
    localparam logic [7:0]  ERR_BUSY   = 8'd1;

    // configuration port
    localparam int          APB_ADDR_W        = 4;
    localparam logic [1:0]  REG_ENTRY_INDEX   = 2'd0;
    localparam logic [1:0]  REG_ATTEMPT_LIMIT = 2'd1;
    localparam logic [1:0]  REG_REPLY_WAIT    = 2'd2;

    localparam logic [6:0]  ENTRY_INDEX_RST   = 7'd1;
    localparam logic [3:0]  ATTEMPT_LIMIT_RST = 4'd3;
    localparam logic [15:0] REPLY_WAIT_RST    = 16'd1000;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } act_t;

    typedef struct packed {
        logic [6:0]  entry_index;
        logic [3:0]  attempt_limit;
        logic [15:0] reply_wait_ticks;
    } cfg_t;

    typedef struct packed {
        cmd_t               command;
        logic               force_update;
        logic signed [31:0] write_value;
        logic [15:0]        rx_descriptor;
        logic [7:0]         rx_byte0;
        logic [7:0]         rx_byte1;
        logic [7:0]         rx_byte2;
        logic [7:0]         rx_byte3;
        logic [7:0]         rx_byte4;
    } item_t;

    typedef struct packed {
        act_t        activity;
        logic [3:0]  attempt_count;
        logic [15:0] wait_count;
        logic [31:0] pending_write;
        logic [31:0] held_value;
        logic        held_valid;
        logic        force_flag;
    } state_t;

    typedef struct packed {
        logic               tx_valid;
        logic [15:0]        tx_descriptor;
        logic [2:0]         tx_length;
        logic [7:0]         tx_byte0;
        logic [7:0]         tx_byte1;
        logic [7:0]         tx_byte2;
        logic [7:0]         tx_byte3;
        logic [7:0]         tx_byte4;
        logic               updated;
        logic signed [31:0] current_value;
        logic               current_valid;
        act_t               pending;
    } result_t;

endpackage

// ----- hdl/rpac_step.sv -----
// ---------------------------------------------------------------------------
// rpac_step
// next-state and result logic for one beat of the parameter client
// ---------------------------------------------------------------------------
module rpac_step (
    input  rpac_pkg::cfg_t    cfg_i,
    input  rpac_pkg::state_t  state_i,
    input  rpac_pkg::item_t   item_i,
    output rpac_pkg::state_t  state_o,
    output rpac_pkg::result_t result_o
);
    import rpac_pkg::*;

    logic        frame_match;
    logic        rpt_req;
    logic        rpt_valid;
    logic        rpt_fire;
    logic [31:0] rpt_value;
    act_t        send_kind;
    state_t      nxt;
    result_t     res;

    assign frame_match = (item_i.rx_descriptor == DESC_REPLY)
                      && (item_i.rx_byte0[6:0] == (cfg_i.entry_index & ID_MASK));

    always_comb begin
        nxt       = state_i;
        send_kind = ACT_NONE;
        rpt_req   = 1'b0;
        rpt_valid = 1'b0;
        rpt_value = state_i.held_value;

        unique case (item_i.command)
            CMD_READ: begin
                nxt.force_flag    = item_i.force_update;
                nxt.activity      = ACT_READ;
                nxt.attempt_count = 4'd1;
                nxt.wait_count    = cfg_i.reply_wait_ticks;
                send_kind         = ACT_READ;
            end
            CMD_WRITE: begin
                nxt.force_flag    = 1'b1;
                nxt.pending_write = $unsigned(item_i.write_value);
                nxt.activity      = ACT_WRITE;
                nxt.attempt_count = 4'd1;
                nxt.wait_count    = cfg_i.reply_wait_ticks;
                send_kind         = ACT_WRITE;
            end
            CMD_FRAME: begin
                if (frame_match) begin
                    nxt.activity      = ACT_NONE;
                    nxt.attempt_count = 4'd0;
                    nxt.wait_count    = 16'd0;
                    if (item_i.rx_byte0[7]) begin
                        if (item_i.rx_byte1 == ERR_BUSY) begin
                            // busy: restart whatever was running, if anything
                            if (state_i.activity != ACT_NONE) begin
                                nxt.activity      = state_i.activity;
                                nxt.attempt_count = 4'd1;
                                nxt.wait_count    = cfg_i.reply_wait_ticks;
                                send_kind         = state_i.activity;
                            end
                        end else begin
                            rpt_req = 1'b1;
                        end
                    end else begin
                        rpt_req   = 1'b1;
                        rpt_valid = 1'b1;
                        rpt_value = {item_i.rx_byte1, item_i.rx_byte2,
                                     item_i.rx_byte3, item_i.rx_byte4};
                    end
                end
            end
            CMD_TICK: begin
                if (state_i.activity != ACT_NONE) begin
                    if (state_i.wait_count > 16'd1) begin
                        nxt.wait_count = state_i.wait_count - 16'd1;
                    end else if (state_i.attempt_count < cfg_i.attempt_limit) begin
                        nxt.attempt_count = state_i.attempt_count + 4'd1;
                        nxt.wait_count    = cfg_i.reply_wait_ticks;
                        send_kind         = state_i.activity;
                    end else begin
                        nxt.activity      = ACT_NONE;
                        nxt.attempt_count = 4'd0;
                        nxt.wait_count    = 16'd0;
                        rpt_req           = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // report only on change or when forced
        rpt_fire = rpt_req && ((rpt_value != nxt.held_value)
                            || (rpt_valid != nxt.held_valid)
                            || nxt.force_flag);
        if (rpt_fire) begin
            nxt.force_flag = 1'b0;
            nxt.held_value = rpt_value;
            nxt.held_valid = rpt_valid;
        end

        res = '0;
        unique case (send_kind)
            ACT_READ: begin
                res.tx_valid      = 1'b1;
                res.tx_descriptor = DESC_QUERY;
                res.tx_length     = LEN_QUERY;
                res.tx_byte0      = {1'b0, cfg_i.entry_index & ID_MASK};
            end
            ACT_WRITE: begin
                res.tx_valid      = 1'b1;
                res.tx_descriptor = DESC_WRITE;
                res.tx_length     = LEN_WRITE;
                res.tx_byte0      = {1'b0, cfg_i.entry_index & ID_MASK};
                res.tx_byte1      = nxt.pending_write[31:24];
                res.tx_byte2      = nxt.pending_write[23:16];
                res.tx_byte3      = nxt.pending_write[15:8];
                res.tx_byte4      = nxt.pending_write[7:0];
            end
            default: ;
        endcase
        res.updated       = rpt_fire;
        res.current_value = $signed(nxt.held_value);
        res.current_valid = nxt.held_valid;
        res.pending       = nxt.activity;
    end

    assign state_o  = nxt;
    assign result_o = res;

endmodule

// ----- hdl/remote_parameter_access_client_core.sv -----
// ---------------------------------------------------------------------------
// remote_parameter_access_client_core
// client for one remote parameter on a frame bus: query and write frames,
// reply wait with resend, value and validity reporting
// ---------------------------------------------------------------------------
//
//  channel   direction  protocol  contents
//  s_axis    in         stream    command (tuser), request and received frame
//  m_axis    out        stream    frame to send, report, held value, activity
//  apb       in/out     apb       entry_index, attempt_limit, reply_wait_ticks
//
//  one beat per cycle sustained while m_axis_tready is high; every input beat gives exactly one result beat
//  a beat passes the input register, then the step logic into the result reg
//  the client state register is updated in the same edge that loads the result
//  m_axis_tready low holds the result; the input register still takes one beat,
//  then s_axis_tready drops until the result moves
//  aresetn (synchronous) restores register defaults and clears activity and value
//
`include "remote_parameter_access_client_core_assert.svh"

module remote_parameter_access_client_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] force_update, [32:1] write_value, [48:33] rx_descriptor,
    // [56:49] rx_byte0, [64:57] rx_byte1, [72:65] rx_byte2,
    // [80:73] rx_byte3, [88:81] rx_byte4, [95:89] zero
    input  logic [rpac_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [rpac_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] tx_valid, [16:1] tx_descriptor, [19:17] tx_length,
    // [27:20] tx_byte0, [35:28] tx_byte1, [43:36] tx_byte2,
    // [51:44] tx_byte3, [59:52] tx_byte4, [60] updated,
    // [92:61] current_value, [93] current_valid, [95:94] pending
    output logic [rpac_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rpac_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rpac_pkg::*;

    // configuration registers
    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        cfg_write;
    logic [1:0]  cfg_sel;

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    item_t       in_item_reg;
    item_t       in_item_next;
    logic        s_accept;

    // client state
    state_t      state_reg;
    state_t      state_next;
    state_t      step_state;
    result_t     step_result;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_result_reg;
    result_t     out_result_next;
    logic        advance;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_sel)
                REG_ENTRY_INDEX:   cfg_next.entry_index      = pwdata[6:0];
                REG_ATTEMPT_LIMIT: cfg_next.attempt_limit    = pwdata[3:0];
                REG_REPLY_WAIT:    cfg_next.reply_wait_ticks = pwdata[15:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ENTRY_INDEX:   prdata = {25'd0, cfg_reg.entry_index};
            REG_ATTEMPT_LIMIT: prdata = {28'd0, cfg_reg.attempt_limit};
            REG_REPLY_WAIT:    prdata = {16'd0, cfg_reg.reply_wait_ticks};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entry_index      <= ENTRY_INDEX_RST;
            cfg_reg.attempt_limit    <= ATTEMPT_LIMIT_RST;
            cfg_reg.reply_wait_ticks <= REPLY_WAIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- handshake and stage control ----------------
    // the step fires when the input register holds a beat and the result
    // register is free or being drained this cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // unpack the input beat
    always_comb begin
        in_item_next               = in_item_reg;
        if (s_accept) begin
            in_item_next.command       = cmd_t'(s_axis_tuser[1:0]);
            in_item_next.force_update  = s_axis_tdata[0];
            in_item_next.write_value   = $signed(s_axis_tdata[32:1]);
            in_item_next.rx_descriptor = s_axis_tdata[48:33];
            in_item_next.rx_byte0      = s_axis_tdata[56:49];
            in_item_next.rx_byte1      = s_axis_tdata[64:57];
            in_item_next.rx_byte2      = s_axis_tdata[72:65];
            in_item_next.rx_byte3      = s_axis_tdata[80:73];
            in_item_next.rx_byte4      = s_axis_tdata[88:81];
        end
    end

    // ---------------- step logic ----------------
    rpac_step u_step (
        .cfg_i    (cfg_reg),
        .state_i  (state_reg),
        .item_i   (in_item_reg),
        .state_o  (step_state),
        .result_o (step_result)
    );

    assign state_next      = advance ? step_state : state_reg;
    assign out_result_next = advance ? step_result : out_result_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{activity: ACT_NONE, attempt_count: 4'd0,
                               wait_count: 16'd0, pending_write: 32'd0,
                               held_value: 32'd0, held_valid: 1'b0,
                               force_flag: 1'b0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    // ---------------- result beat ----------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.pending,
                            out_result_reg.current_valid,
                            out_result_reg.current_value,
                            out_result_reg.updated,
                            out_result_reg.tx_byte4,
                            out_result_reg.tx_byte3,
                            out_result_reg.tx_byte2,
                            out_result_reg.tx_byte1,
                            out_result_reg.tx_byte0,
                            out_result_reg.tx_length,
                            out_result_reg.tx_descriptor,
                            out_result_reg.tx_valid};

    // ---------------- checks ----------------
    // an idle client keeps no attempt count and no running timer
    `RPAC_ASSERT_NOW(a_idle_clean, state_reg.activity == ACT_NONE, state_reg.attempt_count == 4'd0 && state_reg.wait_count == 16'd0, "idle client holds attempt or wait count")
    // a running request has made at least one transmission
    `RPAC_ASSERT_NOW(a_active_attempted, state_reg.activity != ACT_NONE, state_reg.attempt_count != 4'd0, "active request with zero attempts")
    // a frame sent always leaves a request waiting for its reply
    `RPAC_ASSERT_NOW(a_tx_leaves_pending, out_valid_reg && out_result_reg.tx_valid, out_result_reg.pending != ACT_NONE, "frame sent with no request pending")
    // a held input beat is not dropped while the result side stalls
    `RPAC_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg, "input beat lost during stall")

endmodule
